// ----- hw/rtl/hic_pkg.sv -----
// Shared types and constants of the handheld interrupt controller.
`timescale 1ns / 1ps

package hic_pkg;

    // Command codes carried by each input transfer.
    typedef enum logic [2:0] {
        CMD_REQUEST   = 3'd0,
        CMD_WR_FLAGS  = 3'd1,
        CMD_WR_ENABLE = 3'd2,
        CMD_SET_IME   = 3'd3,
        CMD_ACK       = 3'd4,
        CMD_FINISH    = 3'd5,
        CMD_HALT      = 3'd6,
        CMD_STATUS    = 3'd7
    } cmd_t;

    // Configuration register indexes (byte address is four times the index).
    typedef enum logic [1:0] {
        REG_COLOUR_HW   = 2'd0,
        REG_COLOUR_MODE = 2'd1,
        REG_MCYCLE      = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_idx_t;

    localparam logic [7:0] FLAG_TOP       = 8'hE0;
    localparam logic [4:0] SRC_MASK       = 5'h1F;
    localparam logic [4:0] RETRIGGER_DENY = 5'h0C;
    localparam logic [2:0] SRC_LAST       = 3'd4;
    localparam logic [3:0] MCYCLE_RESET   = 4'd4;

    typedef struct packed {
        logic       colour_hardware;
        logic       colour_mode;
        logic [3:0] mcycle_clocks;
    } cfg_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [2:0]  source_index;
        logic [7:0]  data;
        logic [31:0] irq_cycle;
        logic [31:0] now_cycle;
    } item_t;

    typedef struct packed {
        logic [7:0] flag_reg;
        logic [7:0] enable_reg;
        logic       master_enable;
        logic       is_halted;
        logic [4:0] next_source;
        logic       request_denied;
        logic       halt_accepted;
        logic       halt_exit;
        logic       extra_mcycle;
    } result_t;

endpackage

// ----- hw/rtl/hic_cfg.sv -----
// APB-style configuration registers of the interrupt controller.
`timescale 1ns / 1ps

module hic_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output hic_pkg::cfg_t cfg
);

    hic_pkg::cfg_t     cfg_reg;
    hic_pkg::cfg_t     cfg_next;
    hic_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = hic_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                hic_pkg::REG_COLOUR_HW:   cfg_next.colour_hardware = pwdata[0];
                hic_pkg::REG_COLOUR_MODE: cfg_next.colour_mode     = pwdata[0];
                hic_pkg::REG_MCYCLE:      cfg_next.mcycle_clocks   = pwdata[3:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.colour_hardware <= 1'b0;
            cfg_reg.colour_mode     <= 1'b0;
            cfg_reg.mcycle_clocks   <= hic_pkg::MCYCLE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read decode.
    always_comb
    begin
        unique case (idx)
            hic_pkg::REG_COLOUR_HW:   prdata = {31'd0, cfg_reg.colour_hardware};
            hic_pkg::REG_COLOUR_MODE: prdata = {31'd0, cfg_reg.colour_mode};
            hic_pkg::REG_MCYCLE:      prdata = {28'd0, cfg_reg.mcycle_clocks};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

// ----- hw/rtl/hic_in_stage.sv -----
// Input register stage: captures one command transfer per cycle unless it is stalled.
`timescale 1ns / 1ps

module hic_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  hic_pkg::item_t in_item,
    input  logic           take,
    output logic           item_valid,
    output hic_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    hic_pkg::item_t item_reg;
    logic           load;

    // The stage is full only while its item cannot move on.
    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !take);
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- hw/rtl/hic_core.sv -----
// Interrupt state, per-command update logic and the result register.
`timescale 1ns / 1ps

module hic_core (
    input  logic             clk,
    input  logic             rst_n,
    input  hic_pkg::cfg_t    cfg,
    input  logic             item_valid,
    input  hic_pkg::item_t   item,
    output logic             take,
    output logic             out_valid,
    input  logic             out_stall,
    output hic_pkg::result_t result
);

    logic [7:0] flag_bits_reg;
    logic [7:0] flag_bits_next;
    logic [7:0] enable_bits_reg;
    logic [7:0] enable_bits_next;
    logic       master_on_reg;
    logic       master_on_next;
    logic       halted_reg;
    logic       halted_next;
    logic [4:0] dispatch_reg;
    logic [4:0] dispatch_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    hic_pkg::result_t result_reg;
    hic_pkg::result_t result_next;

    logic        fire;
    logic        src_ok;
    logic [4:0]  src_bit;
    logic        deny;
    logic [7:0]  flag_req;
    logic        pend_req;
    logic        pend_now;
    logic [31:0] elapsed;
    logic [3:0]  half_mc;
    logic        young;
    logic [4:0]  pend_next;

    // An item moves on when the result register is free or being drained.
    assign take           = !out_valid_reg || !out_stall;
    assign fire           = item_valid && take;
    assign out_valid_next = fire || (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;
    assign result         = result_reg;

    // Request path: source decode, retrigger denial and halt wake-up.
    always_comb
    begin
        src_ok   = (item.source_index <= hic_pkg::SRC_LAST);
        src_bit  = src_ok ? (5'd1 << item.source_index) : 5'd0;
        deny     = cfg.colour_hardware
                   && ((src_bit & dispatch_reg & hic_pkg::RETRIGGER_DENY) != 5'd0);
        flag_req = flag_bits_reg | {3'd0, src_bit};
        pend_req = (flag_req[4:0] & enable_bits_reg[4:0]) != 5'd0;
        pend_now = (flag_bits_reg[4:0] & enable_bits_reg[4:0]) != 5'd0;
        // A request stamped in the future counts as brand new.
        elapsed  = (item.now_cycle >= item.irq_cycle)
                   ? (item.now_cycle - item.irq_cycle) : 32'd0;
        half_mc  = {1'b0, cfg.mcycle_clocks[3:1]};
        young    = elapsed < {28'd0, half_mc};
    end

    // Command decode and next state.
    always_comb
    begin
        flag_bits_next   = flag_bits_reg;
        enable_bits_next = enable_bits_reg;
        master_on_next   = master_on_reg;
        halted_next      = halted_reg;
        dispatch_next    = dispatch_reg;
        result_next      = '0;
        unique case (item.cmd)
            hic_pkg::CMD_REQUEST:
            begin
                if (src_ok)
                begin
                    if (deny)
                    begin
                        result_next.request_denied = 1'b1;
                    end
                    else
                    begin
                        flag_bits_next = flag_req;
                        if (halted_reg && pend_req)
                        begin
                            halted_next              = 1'b0;
                            result_next.halt_exit    = 1'b1;
                            result_next.extra_mcycle = cfg.colour_mode || young;
                        end
                    end
                end
            end
            hic_pkg::CMD_WR_FLAGS:
            begin
                flag_bits_next = item.data | hic_pkg::FLAG_TOP;
            end
            hic_pkg::CMD_WR_ENABLE:
            begin
                enable_bits_next = item.data;
            end
            hic_pkg::CMD_SET_IME:
            begin
                master_on_next = item.data[0];
            end
            hic_pkg::CMD_ACK:
            begin
                flag_bits_next = (flag_bits_reg & ~{3'd0, item.data[4:0]})
                                 | hic_pkg::FLAG_TOP;
                dispatch_next  = item.data[4:0];
            end
            hic_pkg::CMD_FINISH:
            begin
                master_on_next = 1'b0;
                dispatch_next  = 5'd0;
            end
            hic_pkg::CMD_HALT:
            begin
                if (!pend_now)
                begin
                    halted_next               = 1'b1;
                    result_next.halt_accepted = 1'b1;
                end
            end
            default:
            begin
                halted_next = halted_reg;
            end
        endcase

        // Register view after the command, lowest pending source isolated while the master enable is set.
        pend_next                 = flag_bits_next[4:0] & enable_bits_next[4:0]
                                    & hic_pkg::SRC_MASK;
        result_next.flag_reg      = flag_bits_next;
        result_next.enable_reg    = enable_bits_next;
        result_next.master_enable = master_on_next;
        result_next.is_halted     = halted_next;
        result_next.next_source   = master_on_next ? (pend_next & (~pend_next + 5'd1))
                                                   : 5'd0;
    end

    // Interrupt state and result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_bits_reg   <= hic_pkg::FLAG_TOP;
            enable_bits_reg <= 8'd0;
            master_on_reg   <= 1'b0;
            halted_reg      <= 1'b0;
            dispatch_reg    <= 5'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                flag_bits_reg   <= flag_bits_next;
                enable_bits_reg <= enable_bits_next;
                master_on_reg   <= master_on_next;
                halted_reg      <= halted_next;
                dispatch_reg    <= dispatch_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- hw/rtl/handheld_interrupt_controller_unit.sv -----
// Top level of the handheld interrupt controller.
`timescale 1ns / 1ps

// Five-source interrupt controller. Each command transfer on the request
// channel produces exactly one result transfer, in order. A transfer is
// registered on entry, then evaluated against the interrupt state and
// written to the result register. One command is taken every cycle while
// the result side keeps draining; the result register is the only point
// where the rate can drop, when the consumer stalls. Configuration lives
// at byte addresses 0, 4 and 8 (colour hardware, colour mode, clocks per
// machine cycle) and must only be written while no command is in flight.
// No start-up sweep is needed: the block takes commands as soon as reset
// is released.
module handheld_interrupt_controller_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  cmd,
    input  logic [2:0]  source_index,
    input  logic [7:0]  data,
    input  logic [31:0] irq_cycle,
    input  logic [31:0] now_cycle,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [7:0]  flag_reg,
    output logic [7:0]  enable_reg,
    output logic        master_enable,
    output logic        is_halted,
    output logic [4:0]  next_source,
    output logic        request_denied,
    output logic        halt_accepted,
    output logic        halt_exit,
    output logic        extra_mcycle
);

    hic_pkg::cfg_t    cfg;
    hic_pkg::item_t   in_item;
    hic_pkg::item_t   item;
    hic_pkg::result_t result;
    logic             item_valid;
    logic             take;

    // Pack the request fields.
    assign in_item.cmd          = hic_pkg::cmd_t'(cmd);
    assign in_item.source_index = source_index;
    assign in_item.data         = data;
    assign in_item.irq_cycle    = irq_cycle;
    assign in_item.now_cycle    = now_cycle;

    hic_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hic_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req_valid),
        .in_stall   (req_stall),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    hic_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_valid  (rsp_valid),
        .out_stall  (rsp_stall),
        .result     (result)
    );

    // Unpack the result fields.
    assign flag_reg       = result.flag_reg;
    assign enable_reg     = result.enable_reg;
    assign master_enable  = result.master_enable;
    assign is_halted      = result.is_halted;
    assign next_source    = result.next_source;
    assign request_denied = result.request_denied;
    assign halt_accepted  = result.halt_accepted;
    assign halt_exit      = result.halt_exit;
    assign extra_mcycle   = result.extra_mcycle;

    // An extra machine cycle is only ever reported together with a halt exit.
    a_extra_needs_exit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && extra_mcycle |-> halt_exit)
        else $error("extra machine cycle without halt exit");

    // A halt exit leaves the CPU running, and a halt entry leaves it halted.
    a_halt_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(halt_exit && is_halted) && !(halt_accepted && !is_halted))
        else $error("halt outcome disagrees with halted state");

    // The upper flag bits always read as set.
    a_flag_top: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (flag_reg[7:5] == 3'b111))
        else $error("upper flag bits cleared");

    // The reported source is one-hot or empty and is enabled and flagged.
    a_next_source: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot0(next_source)
                      && ((next_source & ~(flag_reg[4:0] & enable_reg[4:0])) == 5'd0))
        else $error("next source is not a single pending enabled bit");

endmodule

// ----- tb/hic_checker.sv -----
// Checker that predicts and compares every result transfer of the interrupt controller.
`timescale 1ns / 1ps

module hic_checker
    import hic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic [2:0]  cmd,
    input  logic [2:0]  source_index,
    input  logic [7:0]  data,
    input  logic [31:0] irq_cycle,
    input  logic [31:0] now_cycle,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [7:0]  flag_reg,
    input  logic [7:0]  enable_reg,
    input  logic        master_enable,
    input  logic        is_halted,
    input  logic [4:0]  next_source,
    input  logic        request_denied,
    input  logic        halt_accepted,
    input  logic        halt_exit,
    input  logic        extra_mcycle,
    output int          mismatch_count,
    output int          outstanding
);

    // Shadow copy of the configuration registers.
    logic       colour_hw;
    logic       colour_md;
    logic [3:0] mcycle_len;

    // Shadow copy of the interrupt state.
    logic [7:0] if_bits;
    logic [7:0] ie_bits;
    logic       ime;
    logic       halted;
    logic [4:0] dispatching;

    result_t expected_status[$];
    result_t want;
    result_t got;
    item_t   taken;

    // Applies one command to the shadow state and returns the status it reports.
    function automatic result_t interrupt_step(item_t it);
        result_t     r;
        logic [4:0]  src_bit;
        logic [4:0]  pend;
        logic [31:0] span;
        logic [3:0]  half;
        r = '0;
        case (it.cmd)
            CMD_REQUEST:
            begin
                if (it.source_index <= SRC_LAST)
                begin
                    src_bit = 5'd1 << it.source_index;
                    if (((src_bit & dispatching & RETRIGGER_DENY) != 5'd0) && colour_hw)
                    begin
                        r.request_denied = 1'b1;
                    end
                    else
                    begin
                        if_bits = if_bits | {3'b000, src_bit};
                        if (halted && ((if_bits[4:0] & ie_bits[4:0]) != 5'd0))
                        begin
                            halted = 1'b0;
                            r.halt_exit = 1'b1;
                            if (colour_md)
                            begin
                                r.extra_mcycle = 1'b1;
                            end
                            else
                            begin
                                // A request stamped in the future counts as brand new.
                                span = (it.now_cycle >= it.irq_cycle) ?
                                       it.now_cycle - it.irq_cycle : 32'd0;
                                half = mcycle_len >> 1;
                                r.extra_mcycle = (span < {28'd0, half});
                            end
                        end
                    end
                end
            end
            CMD_WR_FLAGS:  if_bits = it.data | FLAG_TOP;
            CMD_WR_ENABLE: ie_bits = it.data;
            CMD_SET_IME:   ime = it.data[0];
            CMD_ACK:
            begin
                if_bits = (if_bits & ~{3'b000, it.data[4:0]}) | FLAG_TOP;
                dispatching = it.data[4:0];
            end
            CMD_FINISH:
            begin
                ime = 1'b0;
                dispatching = 5'd0;
            end
            CMD_HALT:
            begin
                if ((if_bits[4:0] & ie_bits[4:0]) == 5'd0)
                begin
                    halted = 1'b1;
                    r.halt_accepted = 1'b1;
                end
            end
            default: ;
        endcase
        pend = if_bits[4:0] & ie_bits[4:0] & SRC_MASK;
        r.flag_reg      = if_bits;
        r.enable_reg    = ie_bits;
        r.master_enable = ime;
        r.is_halted     = halted;
        r.next_source   = ime ? (pend & (~pend + 5'd1)) : 5'd0;
        return r;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, seen, wanted);
        mismatch_count++;
    endtask

    // Compares an observed status transfer with the oldest prediction.
    task automatic compare_status(input result_t o, input result_t e);
        if (o.flag_reg !== e.flag_reg)
            report_mismatch("flag_reg", 32'(o.flag_reg), 32'(e.flag_reg));
        if (o.enable_reg !== e.enable_reg)
            report_mismatch("enable_reg", 32'(o.enable_reg), 32'(e.enable_reg));
        if (o.master_enable !== e.master_enable)
            report_mismatch("master_enable", 32'(o.master_enable), 32'(e.master_enable));
        if (o.is_halted !== e.is_halted)
            report_mismatch("is_halted", 32'(o.is_halted), 32'(e.is_halted));
        if (o.next_source !== e.next_source)
            report_mismatch("next_source", 32'(o.next_source), 32'(e.next_source));
        if (o.request_denied !== e.request_denied)
            report_mismatch("request_denied", 32'(o.request_denied),
                            32'(e.request_denied));
        if (o.halt_accepted !== e.halt_accepted)
            report_mismatch("halt_accepted", 32'(o.halt_accepted), 32'(e.halt_accepted));
        if (o.halt_exit !== e.halt_exit)
            report_mismatch("halt_exit", 32'(o.halt_exit), 32'(e.halt_exit));
        if (o.extra_mcycle !== e.extra_mcycle)
            report_mismatch("extra_mcycle", 32'(o.extra_mcycle), 32'(e.extra_mcycle));
    endtask

    initial mismatch_count = 0;

    // Track configuration writes, check results, then predict newly accepted commands.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_hw   = 1'b0;
            colour_md   = 1'b0;
            mcycle_len  = MCYCLE_RESET;
            if_bits     = FLAG_TOP;
            ie_bits     = 8'd0;
            ime         = 1'b0;
            halted      = 1'b0;
            dispatching = 5'd0;
            expected_status.delete();
            outstanding = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_COLOUR_HW:   colour_hw  = pwdata[0];
                    REG_COLOUR_MODE: colour_md  = pwdata[0];
                    REG_MCYCLE:      mcycle_len = pwdata[3:0];
                    default: ;
                endcase
            end

            if (rsp_valid && !rsp_stall)
            begin
                got.flag_reg       = flag_reg;
                got.enable_reg     = enable_reg;
                got.master_enable  = master_enable;
                got.is_halted      = is_halted;
                got.next_source    = next_source;
                got.request_denied = request_denied;
                got.halt_accepted  = halt_accepted;
                got.halt_exit      = halt_exit;
                got.extra_mcycle   = extra_mcycle;
                if (expected_status.size() == 0)
                begin
                    report_mismatch("result transfer with none expected", 32'(got), 32'd0);
                end
                else
                begin
                    want = expected_status.pop_front();
                    compare_status(got, want);
                end
            end

            if (req_valid && !req_stall)
            begin
                taken.cmd          = cmd_t'(cmd);
                taken.source_index = source_index;
                taken.data         = data;
                taken.irq_cycle    = irq_cycle;
                taken.now_cycle    = now_cycle;
                expected_status.push_back(interrupt_step(taken));
            end

            outstanding = expected_status.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the interrupt controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import hic_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid;
    logic        req_stall;
    logic [2:0]  cmd;
    logic [2:0]  source_index;
    logic [7:0]  data;
    logic [31:0] irq_cycle;
    logic [31:0] now_cycle;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [7:0]  flag_reg;
    logic [7:0]  enable_reg;
    logic        master_enable;
    logic        is_halted;
    logic [4:0]  next_source;
    logic        request_denied;
    logic        halt_accepted;
    logic        halt_exit;
    logic        extra_mcycle;
    int          mismatch_count;
    int          outstanding;

    int          send_idle_pct;
    int          recv_idle_pct;
    logic        want_hold;
    int          items_sent;

    // Configuration sets, one per random phase; the extremes of every register appear.
    logic        phase_hw[9]   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    logic        phase_mode[9] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    logic [3:0]  phase_mc[9]   = '{4'd4, 4'd2, 4'd8, 4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd2};

    handheld_interrupt_controller_unit dut (.*);

    hic_checker checker_i (.*);

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: random stall, plus one long hold-off once requested.
    initial
    begin
        int held;
        logic hold_done;
        held = 0;
        hold_done = 1'b0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (want_hold && !hold_done)
            begin
                rsp_stall <= 1'b1;
                held++;
                if (held == 300)
                    hold_done = 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Hard limit on the run.
    initial
    begin
        #2_000_000;
        $display("handheld_interrupt_controller_unit: mismatch");
        $finish;
    end

    function automatic item_t make_command(cmd_t c, logic [2:0] s, logic [7:0] d,
                                           logic [31:0] irq, logic [31:0] now);
        item_t it;
        it.cmd          = c;
        it.source_index = s;
        it.data         = d;
        it.irq_cycle    = irq;
        it.now_cycle    = now;
        return it;
    endfunction

    // Offers one command transfer, with random idle cycles ahead of it.
    task automatic send_item(input item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid    <= 1'b1;
        cmd          <= it.cmd;
        source_index <= it.source_index;
        data         <= it.data;
        irq_cycle    <= it.irq_cycle;
        now_cycle    <= it.now_cycle;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Waits for the block to drain, then rewrites all three registers.
    task automatic load_settings(input logic hw, input logic mode, input logic [3:0] mc);
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        apb_write(REG_COLOUR_HW, {31'd0, hw});
        apb_write(REG_COLOUR_MODE, {31'd0, mode});
        apb_write(REG_MCYCLE, {28'd0, mc});
    endtask

    // Request timestamps: mostly a few clocks old, sometimes in the future, sometimes random.
    task automatic pick_times(output logic [31:0] irq, output logic [31:0] now);
        int pick;
        pick = $urandom_range(0, 9);
        now = $urandom;
        if (pick < 6)
            irq = now - 32'($urandom_range(0, 9));
        else if (pick < 8)
            irq = now + 32'($urandom_range(1, 5));
        else
            irq = $urandom;
    endtask

    // Write enables, then flags mostly clear of them, halt, then send one or more wake-up requests.
    task automatic halt_sequence();
        logic [7:0]  en;
        logic [7:0]  fl;
        logic [31:0] irq;
        logic [31:0] now;
        logic [2:0]  src;
        int          reqs;
        en = 8'($urandom);
        if (en[4:0] == 5'd0)
            en[3'($urandom_range(0, 4))] = 1'b1;
        fl = ($urandom_range(0, 3) == 0) ? 8'($urandom) : (8'($urandom) & ~en);
        send_item(make_command(CMD_WR_ENABLE, 3'($urandom), en, $urandom, $urandom));
        send_item(make_command(CMD_WR_FLAGS, 3'($urandom), fl, $urandom, $urandom));
        send_item(make_command(CMD_HALT, 3'($urandom), 8'($urandom), $urandom, $urandom));
        reqs = $urandom_range(1, 3);
        repeat (reqs)
        begin
            pick_times(irq, now);
            src = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            send_item(make_command(CMD_REQUEST, src, 8'($urandom), irq, now));
        end
        if ($urandom_range(0, 1) == 1)
            send_item(make_command(CMD_STATUS, 3'($urandom), 8'($urandom), $urandom, $urandom));
    endtask

    // Enable, request, acknowledge, re-request that source, maybe request source 2 or 3, usually finish.
    task automatic dispatch_sequence();
        int          s;
        logic [31:0] irq;
        logic [31:0] now;
        s = $urandom_range(0, 4);
        send_item(make_command(CMD_SET_IME, 3'($urandom), 8'($urandom) | 8'h01,
                               $urandom, $urandom));
        send_item(make_command(CMD_WR_ENABLE, 3'($urandom), 8'($urandom) | (8'h01 << s),
                               $urandom, $urandom));
        pick_times(irq, now);
        send_item(make_command(CMD_REQUEST, 3'(s), 8'($urandom), irq, now));
        send_item(make_command(CMD_ACK, 3'($urandom), (8'h01 << s) | (8'($urandom) & 8'hE0),
                               $urandom, $urandom));
        pick_times(irq, now);
        send_item(make_command(CMD_REQUEST, 3'(s), 8'($urandom), irq, now));
        if ($urandom_range(0, 1) == 1)
        begin
            pick_times(irq, now);
            send_item(make_command(CMD_REQUEST, 3'($urandom_range(2, 3)), 8'($urandom),
                                   irq, now));
        end
        if ($urandom_range(0, 9) < 7)
            send_item(make_command(CMD_FINISH, 3'($urandom), 8'($urandom), $urandom, $urandom));
    endtask

    // Mostly well-formed sequences, with some fully random commands mixed in.
    task automatic run_random(input int n);
        int target;
        int pick;
        int burst;
        target = items_sent + n;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
            begin
                dispatch_sequence();
            end
            else if (pick < 76)
            begin
                halt_sequence();
            end
            else
            begin
                burst = $urandom_range(1, 3);
                repeat (burst)
                    send_item(make_command(cmd_t'($urandom_range(0, 7)), 3'($urandom),
                                           8'($urandom), $urandom, $urandom));
            end
        end
    endtask

    // Main stimulus: reset, directed commands, random phases, drain, verdict.
    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 4'd0;
        pwdata        = 32'd0;
        req_valid     = 1'b0;
        cmd           = CMD_STATUS;
        source_index  = 3'd0;
        data          = 8'd0;
        irq_cycle     = 32'd0;
        now_cycle     = 32'd0;
        send_idle_pct = 16;
        recv_idle_pct = 72;
        want_hold     = 1'b0;
        items_sent    = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part on colour hardware, normal mode and the reset value of clocks per machine cycle.
        load_settings(1'b1, 1'b0, 4'd4);
        send_item(make_command(CMD_STATUS, 3'd0, 8'h00, 32'd0, 32'd0));
        send_item(make_command(CMD_WR_FLAGS, 3'd0, 8'hFF, 32'd0, 32'd0));
        send_item(make_command(CMD_WR_FLAGS, 3'd0, 8'h00, 32'd0, 32'd0));
        send_item(make_command(CMD_WR_ENABLE, 3'd0, 8'hFF, 32'd0, 32'd0));
        send_item(make_command(CMD_WR_ENABLE, 3'd0, 8'h00, 32'd0, 32'd0));
        send_item(make_command(CMD_SET_IME, 3'd0, 8'hFE, 32'd0, 32'd0));
        send_item(make_command(CMD_SET_IME, 3'd0, 8'h01, 32'd0, 32'd0));
        send_item(make_command(CMD_WR_ENABLE, 3'd0, 8'h1F, 32'd0, 32'd0));
        send_item(make_command(CMD_HALT, 3'd0, 8'h00, 32'd0, 32'd0));
        // Flag write while halted, then a future-stamped wake-up at the counter extremes.
        send_item(make_command(CMD_WR_FLAGS, 3'd0, 8'h00, 32'd0, 32'd0));
        send_item(make_command(CMD_REQUEST, 3'd0, 8'h00, 32'hFFFF_FFFF, 32'd0));
        send_item(make_command(CMD_HALT, 3'd0, 8'h00, 32'd0, 32'd0));
        send_item(make_command(CMD_ACK, 3'd0, 8'hE1, 32'd0, 32'd0));
        send_item(make_command(CMD_WR_FLAGS, 3'd0, 8'h00, 32'd0, 32'd0));
        send_item(make_command(CMD_HALT, 3'd0, 8'h00, 32'd0, 32'd0));
        send_item(make_command(CMD_HALT, 3'd0, 8'h00, 32'd0, 32'd0));
        // Old request: no extra machine cycle.
        send_item(make_command(CMD_REQUEST, 3'd4, 8'h00, 32'd90, 32'd100));
        send_item(make_command(CMD_WR_FLAGS, 3'd0, 8'h00, 32'd0, 32'd0));
        send_item(make_command(CMD_HALT, 3'd0, 8'h00, 32'd0, 32'd0));
        // Young request: extra machine cycle.
        send_item(make_command(CMD_REQUEST, 3'd2, 8'h00, 32'd99, 32'd100));
        // Timer retrigger while it is being dispatched is refused; serial is not.
        send_item(make_command(CMD_ACK, 3'd0, 8'h04, 32'd0, 32'd0));
        send_item(make_command(CMD_REQUEST, 3'd2, 8'h00, 32'd0, 32'd0));
        send_item(make_command(CMD_REQUEST, 3'd3, 8'h00, 32'd0, 32'd0));
        // Out-of-range sources are ignored.
        send_item(make_command(CMD_REQUEST, 3'd5, 8'hFF, 32'd0, 32'd0));
        send_item(make_command(CMD_REQUEST, 3'd7, 8'hFF, 32'd0, 32'd0));
        send_item(make_command(CMD_FINISH, 3'd0, 8'h00, 32'd0, 32'd0));

        // Random phases: sender-light idling, then receiver-light, then none.
        for (int ph = 0; ph < 9; ph++)
        begin
            load_settings(phase_hw[4'(ph)], phase_mode[4'(ph)], phase_mc[4'(ph)]);
            if (ph < 3)
            begin
                send_idle_pct = 16;
                recv_idle_pct = 72;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 16;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Long result-side hold-off while commands keep coming.
            if (ph == 6)
                want_hold = 1'b1;
            run_random(115);
        end

        // Drain and let the pipeline settle.
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("handheld_interrupt_controller_unit: match");
        else
            $display("handheld_interrupt_controller_unit: mismatch");
        $finish;
    end

endmodule

// ----- handheld_interrupt_controller_unit.f -----
hw/rtl/hic_pkg.sv
hw/rtl/hic_cfg.sv
hw/rtl/hic_in_stage.sv
hw/rtl/hic_core.sv
hw/rtl/handheld_interrupt_controller_unit.sv
tb/hic_checker.sv
tb/tb_top.sv
